@@ hdl/evad_pkg.sv @@
// shared types and constants of the energy voice activity detector
package evad_pkg;

   localparam int BAND_W      = 32;
   localparam int ACC_W       = 40;
   localparam int NORM_W      = ACC_W + 1;
   localparam int P_W         = 6;
   localparam int E_W         = 20;
   localparam int CNT_W       = 4;
   localparam int RUN_W       = 8;
   localparam int EST_W       = 16;
   localparam int LME_W       = 14;
   localparam int INV_W       = 32;
   localparam int MARGIN_W    = 16;
   localparam int MUL_A_W     = NORM_W;
   localparam int MUL_B_W     = 16;
   localparam int PROD_W      = MUL_A_W + MUL_B_W;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int SUM_FRAC    = 16;
   localparam int OFFS_Q16    = 3800;

   localparam logic [P_W-1:0]     MSB_POS    = P_W'(NORM_W - 1);
   localparam logic [MUL_B_W-1:0] LN2_Q16    = 16'd45426;
   localparam logic [PROD_W-1:0]  ROUND_HALF = PROD_W'(32768);
   localparam logic [CNT_W-1:0]   FC_MAX     = '1;
   localparam logic [RUN_W-1:0]   RUN_MAX    = '1;
   localparam logic [E_W-1:0]     E_MAX      = '1;

   localparam logic [LME_W-1:0]    RST_LOG_MAX_ENERGY    = 14'd2048;
   localparam logic [INV_W-1:0]    RST_INV_ENERGY_SCALE  = 32'd4294967;
   localparam logic [MARGIN_W-1:0] RST_INV_REDUCTION     = 16'd655;
   localparam logic [MARGIN_W-1:0] RST_UPDATE_MARGIN     = 16'd5120;
   localparam logic [MARGIN_W-1:0] RST_SPEECH_MARGIN     = 16'd1152;
   localparam logic [RUN_W-1:0]    RST_MIN_SPEECH_FRAMES = 8'd3;
   localparam logic [RUN_W-1:0]    RST_HANGOVER_FRAMES   = 8'd6;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LOG_MAX_ENERGY    = 3'd0,
      CSR_INV_ENERGY_SCALE  = 3'd1,
      CSR_INV_REDUCTION     = 3'd2,
      CSR_UPDATE_MARGIN     = 3'd3,
      CSR_SPEECH_MARGIN     = 3'd4,
      CSR_MIN_SPEECH_FRAMES = 3'd5,
      CSR_HANGOVER_FRAMES   = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      GAIN_32  = 2'd0,
      GAIN_64  = 2'd1,
      GAIN_128 = 2'd2
   } gain_type;

   typedef struct packed {
      logic [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0] b;
   } mul_req_type;

endpackage

@@ hdl/evad_if.sv @@
// channel interfaces of the energy voice activity detector
interface evad_req_if import evad_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BAND_W-1:0] band_energy;
   logic              last_band;
   modport source (output valid, band_energy, last_band, input ready);
   modport sink (input valid, band_energy, last_band, output ready);
endinterface

interface evad_rsp_if import evad_pkg::*; ();
   logic           valid;
   logic           ready;
   logic           speech_active;
   logic [E_W-1:0] frame_log_energy;
   logic [E_W-1:0] noise_level;
   modport source (output valid, speech_active, frame_log_energy, noise_level, input ready);
   modport sink (input valid, speech_active, frame_log_energy, noise_level, output ready);
endinterface

interface evad_csr_if import evad_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/energy_voice_activity_detector.sv @@
// top level of the energy voice activity detector
//
//  channel   dir  payload                                         handshake
//  req_chan  in   band_energy[31:0], last_band                    valid/ready
//  rsp_chan  out  speech_active, frame_log_energy, noise_level    valid/ready
//  csr_chan  in   index[2:0], data[31:0]                          valid/ready
//
// a band word without last_band is added into the saturating band sum
// a last band word holds req_chan off until its decision is registered; the hold is set by the one bit
// a cycle normaliser of the log unit (run twice in the first frames), the shared multiplier and
// a decision still waiting on rsp_chan; reset is synchronous; no clearing pass
// band words are taken while a decision waits on rsp_chan; a new decision waits for it
module energy_voice_activity_detector import evad_pkg::*; #(
   parameter int unsigned INIT_FRAMES   = 10,
   parameter int unsigned LOG_FRAC_BITS = 8
) (
   input logic        clock,
   input logic        reset,
   evad_req_if.sink   req_chan,
   evad_rsp_if.source rsp_chan,
   evad_csr_if.sink   csr_chan
);

   localparam int L2W  = LOG_FRAC_BITS + 7;
   localparam int LNW  = LOG_FRAC_BITS + 6;
   localparam int EW   = LNW + EST_W + 1;
   localparam int CW   = LOG_FRAC_BITS + 30;
   localparam int EFW  = LNW + 14;
   localparam int DW   = E_W + 1;
   localparam int NW   = E_W + 2;
   localparam int OFFS = (OFFS_Q16 + (1 << (15 - LOG_FRAC_BITS))) >> (16 - LOG_FRAC_BITS);
   localparam logic [L2W-1:0]   OFFS_L   = L2W'(OFFS);
   localparam logic [CNT_W-1:0] INIT_CNT = CNT_W'(INIT_FRAMES);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_NORM,
      ST_LN_MUL,
      ST_LN_RES,
      ST_EST,
      ST_GAIN,
      ST_RATIO_HI,
      ST_RATIO_LO,
      ST_RATIO_ADD,
      ST_EF,
      ST_EM,
      ST_DECIDE,
      ST_STEP_MUL,
      ST_STEP_RES,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [LME_W-1:0]    log_max_energy_ff, log_max_energy_in;
   logic [INV_W-1:0]    inv_energy_scale_ff, inv_energy_scale_in;
   logic [MARGIN_W-1:0] inv_reduction_ff, inv_reduction_in;
   logic [MARGIN_W-1:0] update_margin_ff, update_margin_in;
   logic [MARGIN_W-1:0] speech_margin_ff, speech_margin_in;
   logic [RUN_W-1:0]    min_speech_frames_ff, min_speech_frames_in;
   logic [RUN_W-1:0]    hangover_frames_ff, hangover_frames_in;

   // frame state
   logic [ACC_W-1:0]        energy_sum_ff, energy_sum_in;
   logic [CNT_W-1:0]        frame_count_ff, frame_count_in;
   logic signed [EST_W-1:0] est_ff, est_in;
   gain_type                gain_ff, gain_in;
   logic [E_W-1:0]          noise_ff, noise_in;
   logic [RUN_W-1:0]        run_ff, run_in;
   logic [RUN_W-1:0]        hang_ff, hang_in;

   // working registers
   logic [ACC_W-1:0]      frame_sum_ff, frame_sum_in;
   logic [NORM_W-1:0]     norm_x_ff, norm_x_in;
   logic [P_W-1:0]        p_ff, p_in;
   logic                  second_ff, second_in;
   logic signed [L2W-1:0] l2_ff, l2_in;
   logic signed [LNW-1:0] ln_ff, ln_in;
   logic [PROD_W-1:0]     p1_ff, p1_in;
   logic [E_W-1:0]        ef_ff, ef_in;
   logic                  speech_ff, speech_in;

   // result register
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_speech_ff, rsp_speech_in;
   logic [E_W-1:0] rsp_energy_ff, rsp_energy_in;
   logic [E_W-1:0] rsp_noise_ff, rsp_noise_in;

   mul_req_type       mul_req;
   logic [PROD_W-1:0] product;

   // datapath terms
   logic [NORM_W-1:0]     sum_wide;
   logic [ACC_W-1:0]      sum_sat;
   logic signed [6:0]     p_rel;
   logic [LOG_FRAC_BITS-1:0] frac;
   logic signed [L2W-1:0] l2_calc;
   logic [L2W-1:0]        l2_mag;
   logic [PROD_W-1:0]     ln_rnd;
   logic [LNW-1:0]        ln_r;
   logic signed [LNW-1:0] ln_calc;
   logic signed [EW-1:0]  est_sum;
   logic signed [EW-1:0]  est_v;
   logic [EST_W-1:0]      est_calc;
   logic signed [CW-1:0]  gain_lhs, gain_rhs, gain_rhs6, gain_rhs7;
   logic [PROD_W-1:0]     ratio_t;
   logic [NORM_W-1:0]     ratio_x;
   logic [2:0]            gain_shift;
   logic [EFW-1:0]        ef_wide;
   logic [E_W-1:0]        ef_calc;
   logic [DW-1:0]         em_avg;
   logic signed [DW-1:0]  d;
   logic [DW-1:0]         d_mag;
   logic signed [CW-1:0]  d_scaled, sm_scaled, um_scaled;
   logic                  is_speech, do_update;
   logic [RUN_W-1:0]      hang_cur;
   logic [DW-1:0]         step;
   logic signed [NW-1:0]  noise_step;
   logic [E_W-1:0]        noise_calc;

   evad_mul u_mul (
      .clock      (clock),
      .mul_req    (mul_req),
      .product_ff (product)
   );

   assign req_chan.ready            = (state_ff == ST_IDLE);
   assign csr_chan.ready            = 1'b1;
   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.speech_active    = rsp_speech_ff;
   assign rsp_chan.frame_log_energy = rsp_energy_ff;
   assign rsp_chan.noise_level      = rsp_noise_ff;

   // saturating band sum
   assign sum_wide = {1'b0, energy_sum_ff} + NORM_W'(req_chan.band_energy);
   assign sum_sat  = sum_wide[NORM_W-1] ? '1 : sum_wide[ACC_W-1:0];

   // base-2 log from the normalised word
   assign p_rel   = (norm_x_ff == '0) ? -7'sd17
                                      : signed'({1'b0, p_ff}) - 7'(SUM_FRAC);
   assign frac    = norm_x_ff[NORM_W-2 -: LOG_FRAC_BITS];
   assign l2_calc = (L2W'(p_rel) <<< LOG_FRAC_BITS) + L2W'(frac) + OFFS_L;
   assign l2_mag  = l2_ff[L2W-1] ? unsigned'(-l2_ff) : unsigned'(l2_ff);

   // scale by ln2, round half away from zero
   assign ln_rnd  = product + ROUND_HALF;
   assign ln_r    = ln_rnd[16 +: LNW];
   assign ln_calc = l2_ff[L2W-1] ? -signed'(ln_r) : signed'(ln_r);

   // initial estimate, floor average and clamp
   assign est_sum = EW'(est_ff) + EW'(ln_ff);
   assign est_v   = (frame_count_ff == '0) ? EW'(ln_ff) : (est_sum >>> 1);

   always_comb begin
      if (est_v > EW'(32767)) begin
         est_calc = 16'h7FFF;
      end else if (est_v < EW'(-32768)) begin
         est_calc = 16'h8000;
      end else begin
         est_calc = est_v[EST_W-1:0];
      end
   end

   // gain thresholds at 6/9 and 7/9
   assign gain_lhs  = (CW'(est_ff) <<< 11) + (CW'(est_ff) <<< 8);
   assign gain_rhs  = signed'(CW'(log_max_energy_ff)) <<< LOG_FRAC_BITS;
   assign gain_rhs6 = (gain_rhs <<< 2) + (gain_rhs <<< 1);
   assign gain_rhs7 = (gain_rhs <<< 3) - gain_rhs;

   // sum / w with the split inverse
   assign ratio_t = p1_ff + (product >> 16);
   assign ratio_x = ratio_t[PROD_W-1 -: NORM_W] + NORM_W'(1 << SUM_FRAC);

   // frame energy
   always_comb begin
      unique case (gain_ff)
         GAIN_32: gain_shift = 3'd5;
         GAIN_64: gain_shift = 3'd6;
         default: gain_shift = 3'd7;
      endcase
   end

   assign ef_wide = EFW'(unsigned'(ln_ff)) << gain_shift;

   always_comb begin
      if (ln_ff[LNW-1]) begin
         ef_calc = '0;
      end else if (ef_wide > EFW'(E_MAX)) begin
         ef_calc = E_MAX;
      end else begin
         ef_calc = ef_wide[E_W-1:0];
      end
   end

   assign em_avg = DW'(noise_ff) + DW'(ef_ff);

   // decision terms
   assign d         = signed'({1'b0, ef_ff}) - signed'({1'b0, noise_ff});
   assign d_mag     = d[DW-1] ? unsigned'(-d) : unsigned'(d);
   assign d_scaled  = CW'(d) <<< 8;
   assign sm_scaled = signed'(CW'(speech_margin_ff)) <<< LOG_FRAC_BITS;
   assign um_scaled = signed'(CW'(update_margin_ff)) <<< LOG_FRAC_BITS;
   assign is_speech = d_scaled > sm_scaled;
   assign do_update = d_scaled < um_scaled;
   assign hang_cur  = (run_ff > min_speech_frames_ff) ? hangover_frames_ff : hang_ff;

   // noise adaptation step
   assign step       = product[16 +: DW];
   assign noise_step = d[DW-1] ? signed'(NW'(noise_ff)) - signed'(NW'(step))
                               : signed'(NW'(noise_ff)) + signed'(NW'(step));

   always_comb begin
      if (noise_step < 0) begin
         noise_calc = '0;
      end else if (noise_step > signed'(NW'(E_MAX))) begin
         noise_calc = E_MAX;
      end else begin
         noise_calc = noise_step[E_W-1:0];
      end
   end

   always_comb begin
      state_in             = state_ff;
      log_max_energy_in    = log_max_energy_ff;
      inv_energy_scale_in  = inv_energy_scale_ff;
      inv_reduction_in     = inv_reduction_ff;
      update_margin_in     = update_margin_ff;
      speech_margin_in     = speech_margin_ff;
      min_speech_frames_in = min_speech_frames_ff;
      hangover_frames_in   = hangover_frames_ff;
      energy_sum_in        = energy_sum_ff;
      frame_count_in       = frame_count_ff;
      est_in               = est_ff;
      gain_in              = gain_ff;
      noise_in             = noise_ff;
      run_in               = run_ff;
      hang_in              = hang_ff;
      frame_sum_in         = frame_sum_ff;
      norm_x_in            = norm_x_ff;
      p_in                 = p_ff;
      second_in            = second_ff;
      l2_in                = l2_ff;
      ln_in                = ln_ff;
      p1_in                = p1_ff;
      ef_in                = ef_ff;
      speech_in            = speech_ff;
      rsp_valid_in         = rsp_valid_ff;
      rsp_speech_in        = rsp_speech_ff;
      rsp_energy_in        = rsp_energy_ff;
      rsp_noise_in         = rsp_noise_ff;
      mul_req.a            = MUL_A_W'(frame_sum_ff);
      mul_req.b            = inv_energy_scale_ff[INV_W-1 -: MUL_B_W];

      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_LOG_MAX_ENERGY:    log_max_energy_in    = csr_chan.data[LME_W-1:0];
            CSR_INV_ENERGY_SCALE:  inv_energy_scale_in  = csr_chan.data[INV_W-1:0];
            CSR_INV_REDUCTION:     inv_reduction_in     = csr_chan.data[MARGIN_W-1:0];
            CSR_UPDATE_MARGIN:     update_margin_in     = csr_chan.data[MARGIN_W-1:0];
            CSR_SPEECH_MARGIN:     speech_margin_in     = csr_chan.data[MARGIN_W-1:0];
            CSR_MIN_SPEECH_FRAMES: min_speech_frames_in = csr_chan.data[RUN_W-1:0];
            CSR_HANGOVER_FRAMES:   hangover_frames_in   = csr_chan.data[RUN_W-1:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               if (!req_chan.last_band) begin
                  energy_sum_in = sum_sat;
               end else begin
                  energy_sum_in = '0;
                  frame_sum_in  = sum_sat;
                  if (frame_count_ff < INIT_CNT) begin
                     norm_x_in = {1'b0, sum_sat};
                     p_in      = MSB_POS;
                     second_in = 1'b0;
                     state_in  = ST_NORM;
                  end else begin
                     state_in = ST_RATIO_HI;
                  end
               end
            end
         end
         ST_NORM: begin
            if ((norm_x_ff == '0) || norm_x_ff[NORM_W-1]) begin
               l2_in    = l2_calc;
               state_in = ST_LN_MUL;
            end else begin
               norm_x_in = norm_x_ff << 1;
               p_in      = p_ff - 1'b1;
            end
         end
         ST_LN_MUL: begin
            mul_req.a = MUL_A_W'(l2_mag);
            mul_req.b = LN2_Q16;
            state_in  = ST_LN_RES;
         end
         ST_LN_RES: begin
            ln_in    = ln_calc;
            state_in = second_ff ? ST_EF : ST_EST;
         end
         ST_EST: begin
            est_in   = signed'(est_calc);
            state_in = ST_GAIN;
         end
         ST_GAIN: begin
            priority if (gain_lhs < gain_rhs6) begin
               gain_in = GAIN_32;
            end else if (gain_lhs < gain_rhs7) begin
               gain_in = GAIN_64;
            end else begin
               gain_in = GAIN_128;
            end
            state_in = ST_RATIO_HI;
         end
         ST_RATIO_HI: begin
            state_in = ST_RATIO_LO;
         end
         ST_RATIO_LO: begin
            p1_in     = product;
            mul_req.b = inv_energy_scale_ff[MUL_B_W-1:0];
            state_in  = ST_RATIO_ADD;
         end
         ST_RATIO_ADD: begin
            norm_x_in = ratio_x;
            p_in      = MSB_POS;
            second_in = 1'b1;
            state_in  = ST_NORM;
         end
         ST_EF: begin
            ef_in    = ef_calc;
            state_in = ST_EM;
         end
         ST_EM: begin
            if (frame_count_ff == '0) begin
               noise_in = ef_ff;
            end else if (frame_count_ff < INIT_CNT) begin
               noise_in = em_avg[DW-1:1];
            end
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (is_speech) begin
               if (run_ff != RUN_MAX) begin
                  run_in = run_ff + 1'b1;
               end
               speech_in = 1'b1;
            end else begin
               run_in = '0;
               if (hang_cur == '0) begin
                  hang_in   = hang_cur;
                  speech_in = 1'b0;
               end else begin
                  hang_in   = hang_cur - 1'b1;
                  speech_in = 1'b1;
               end
            end
            state_in = do_update ? ST_STEP_MUL : ST_FINISH;
         end
         ST_STEP_MUL: begin
            mul_req.a = MUL_A_W'(d_mag);
            mul_req.b = inv_reduction_ff;
            state_in  = ST_STEP_RES;
         end
         ST_STEP_RES: begin
            noise_in = noise_calc;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_speech_in = speech_ff;
               rsp_energy_in = ef_ff;
               rsp_noise_in  = noise_ff;
               if (frame_count_ff != FC_MAX) begin
                  frame_count_in = frame_count_ff + 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff             <= ST_IDLE;
         log_max_energy_ff    <= RST_LOG_MAX_ENERGY;
         inv_energy_scale_ff  <= RST_INV_ENERGY_SCALE;
         inv_reduction_ff     <= RST_INV_REDUCTION;
         update_margin_ff     <= RST_UPDATE_MARGIN;
         speech_margin_ff     <= RST_SPEECH_MARGIN;
         min_speech_frames_ff <= RST_MIN_SPEECH_FRAMES;
         hangover_frames_ff   <= RST_HANGOVER_FRAMES;
         energy_sum_ff        <= '0;
         frame_count_ff       <= '0;
         est_ff               <= '0;
         gain_ff              <= GAIN_32;
         noise_ff             <= '0;
         run_ff               <= '0;
         hang_ff              <= '0;
         rsp_valid_ff         <= 1'b0;
      end else begin
         state_ff             <= state_in;
         log_max_energy_ff    <= log_max_energy_in;
         inv_energy_scale_ff  <= inv_energy_scale_in;
         inv_reduction_ff     <= inv_reduction_in;
         update_margin_ff     <= update_margin_in;
         speech_margin_ff     <= speech_margin_in;
         min_speech_frames_ff <= min_speech_frames_in;
         hangover_frames_ff   <= hangover_frames_in;
         energy_sum_ff        <= energy_sum_in;
         frame_count_ff       <= frame_count_in;
         est_ff               <= est_in;
         gain_ff              <= gain_in;
         noise_ff             <= noise_in;
         run_ff               <= run_in;
         hang_ff              <= hang_in;
         rsp_valid_ff         <= rsp_valid_in;
         frame_sum_ff         <= frame_sum_in;
         norm_x_ff            <= norm_x_in;
         p_ff                 <= p_in;
         second_ff            <= second_in;
         l2_ff                <= l2_in;
         ln_ff                <= ln_in;
         p1_ff                <= p1_in;
         ef_ff                <= ef_in;
         speech_ff            <= speech_in;
         rsp_speech_ff        <= rsp_speech_in;
         rsp_energy_ff        <= rsp_energy_in;
         rsp_noise_ff         <= rsp_noise_in;
      end
   end

endmodule

@@ hdl/evad_mul.sv @@
// shared registered multiplier of the detector datapath
module evad_mul import evad_pkg::*; (
   input  logic              clock,
   input  mul_req_type       mul_req,
   output logic [PROD_W-1:0] product_ff
);

   logic [PROD_W-1:0] product_in;

   assign product_in = PROD_W'(mul_req.a) * PROD_W'(mul_req.b);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

endmodule

@@ tb/evad_decision_check.sv @@
// checker that predicts each frame decision of the detector from the observed words
`timescale 1ns / 1ps

module evad_decision_check import evad_pkg::*; (
   input  logic clock,
   input  logic reset,
   evad_req_if  req_mon,
   evad_rsp_if  rsp_mon,
   evad_csr_if  csr_mon,
   output int   fails,
   output int   pending
);

   localparam int LOG_FRAC = 8;
   localparam int WARMUP_FRAMES = 10;
   localparam longint LN_OFFSET = (OFFS_Q16 + (1 << (15 - LOG_FRAC))) >> (16 - LOG_FRAC);
   localparam logic [ACC_W-1:0] TOTAL_MAX = '1;

   typedef struct packed {
      logic           speech;
      logic [E_W-1:0] energy;
      logic [E_W-1:0] noise;
   } decision_type;

   logic [LME_W-1:0]    max_log_cfg;
   logic [INV_W-1:0]    inv_scale_cfg;
   logic [MARGIN_W-1:0] inv_red_cfg;
   logic [MARGIN_W-1:0] upd_margin_cfg;
   logic [MARGIN_W-1:0] spch_margin_cfg;
   logic [RUN_W-1:0]    min_run_cfg;
   logic [RUN_W-1:0]    hold_cfg;

   logic [ACC_W-1:0]        band_total;
   logic [CNT_W-1:0]        frames_seen;
   logic signed [EST_W-1:0] log_estimate;
   gain_type                gain;
   logic [E_W-1:0]          noise_est;
   logic [RUN_W-1:0]        run_len;
   logic [RUN_W-1:0]        hold_left;

   decision_type decision_q[$];
   int           mismatches = 0;

   // ln2 * (msb - SUM_FRAC + mantissa fraction + offset), LOG_FRAC fractional bits
   function automatic longint ln_q8(input logic [63:0] x);
      int          msb;
      logic [63:0] frac;
      longint      l2, mag, r;
      msb = -1;
      frac = '0;
      for (int i = 0; i < 64; i++) begin
         if (x[i]) msb = i;
      end
      if (msb >= 0) frac = ((x - (64'd1 << msb)) << LOG_FRAC) >> msb;
      l2 = longint'(msb - SUM_FRAC) * (longint'(1) << LOG_FRAC) + longint'(frac) + LN_OFFSET;
      mag = (l2 < 0) ? -l2 : l2;
      r = (mag * longint'(LN2_Q16) + 32768) / 65536;
      return (l2 < 0) ? -r : r;
   endfunction

   function automatic decision_type judge_frame(input logic [ACC_W-1:0] total);
      decision_type res;
      longint       ln, est, lhs, rhs, ef, em, d, step;
      logic [63:0]  sum64, inv_hi, inv_lo, ratio;
      logic         speech;
      sum64 = 64'(total);
      if (frames_seen < WARMUP_FRAMES) begin
         ln = ln_q8(sum64);
         est = (frames_seen == 0) ? ln : ((longint'(log_estimate) + ln) >>> 1);
         if (est > 32767) est = 32767;
         else if (est < -32768) est = -32768;
         log_estimate = est[EST_W-1:0];
         lhs = est * 9 * 256;
         rhs = longint'(max_log_cfg) << LOG_FRAC;
         if (lhs < 6 * rhs) gain = GAIN_32;
         else if (lhs < 7 * rhs) gain = GAIN_64;
         else gain = GAIN_128;
      end
      inv_hi = 64'(inv_scale_cfg[31:16]);
      inv_lo = 64'(inv_scale_cfg[15:0]);
      ratio = (sum64 * inv_hi + ((sum64 * inv_lo) >> 16)) >> 16;
      ln = ln_q8(ratio + (64'd1 << SUM_FRAC));
      case (gain)
         GAIN_32: ef = ln * 32;
         GAIN_64: ef = ln * 64;
         default: ef = ln * 128;
      endcase
      if (ef > longint'(E_MAX)) ef = longint'(E_MAX);
      if (ef < 0) ef = 0;
      em = longint'(noise_est);
      if (frames_seen == 0) em = ef;
      else if (frames_seen < WARMUP_FRAMES) em = (em + ef) / 2;
      d = ef - em;
      if (d > longint'(spch_margin_cfg)) begin
         if (run_len != RUN_MAX) run_len = run_len + 1'b1;
         speech = 1'b1;
      end else begin
         if (run_len > min_run_cfg) hold_left = hold_cfg;
         run_len = '0;
         if (hold_left == 0) begin
            speech = 1'b0;
         end else begin
            hold_left = hold_left - 1'b1;
            speech = 1'b1;
         end
      end
      if (d < longint'(upd_margin_cfg)) begin
         step = ((d < 0) ? -d : d) * longint'(inv_red_cfg) / 65536;
         em = (d < 0) ? em - step : em + step;
         if (em < 0) em = 0;
         if (em > longint'(E_MAX)) em = longint'(E_MAX);
      end
      noise_est = em[E_W-1:0];
      if (frames_seen != FC_MAX) frames_seen = frames_seen + 1'b1;
      res.speech = speech;
      res.energy = ef[E_W-1:0];
      res.noise = em[E_W-1:0];
      return res;
   endfunction

   always @(posedge clock) begin : watch
      logic [ACC_W:0] wide;
      decision_type   want, got;
      if (reset) begin
         max_log_cfg = RST_LOG_MAX_ENERGY;
         inv_scale_cfg = RST_INV_ENERGY_SCALE;
         inv_red_cfg = RST_INV_REDUCTION;
         upd_margin_cfg = RST_UPDATE_MARGIN;
         spch_margin_cfg = RST_SPEECH_MARGIN;
         min_run_cfg = RST_MIN_SPEECH_FRAMES;
         hold_cfg = RST_HANGOVER_FRAMES;
         band_total = '0;
         frames_seen = '0;
         log_estimate = '0;
         gain = GAIN_32;
         noise_est = '0;
         run_len = '0;
         hold_left = '0;
         decision_q.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_index_type'(csr_mon.index))
               CSR_LOG_MAX_ENERGY:    max_log_cfg = csr_mon.data[LME_W-1:0];
               CSR_INV_ENERGY_SCALE:  inv_scale_cfg = csr_mon.data[INV_W-1:0];
               CSR_INV_REDUCTION:     inv_red_cfg = csr_mon.data[MARGIN_W-1:0];
               CSR_UPDATE_MARGIN:     upd_margin_cfg = csr_mon.data[MARGIN_W-1:0];
               CSR_SPEECH_MARGIN:     spch_margin_cfg = csr_mon.data[MARGIN_W-1:0];
               CSR_MIN_SPEECH_FRAMES: min_run_cfg = csr_mon.data[RUN_W-1:0];
               CSR_HANGOVER_FRAMES:   hold_cfg = csr_mon.data[RUN_W-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            wide = (ACC_W+1)'(band_total) + (ACC_W+1)'(req_mon.band_energy);
            if (wide > (ACC_W+1)'(TOTAL_MAX)) wide = (ACC_W+1)'(TOTAL_MAX);
            if (req_mon.last_band) begin
               band_total = '0;
               decision_q.push_back(judge_frame(wide[ACC_W-1:0]));
            end else begin
               band_total = wide[ACC_W-1:0];
            end
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = {rsp_mon.speech_active, rsp_mon.frame_log_energy, rsp_mon.noise_level};
            if (decision_q.size() == 0) begin
               mismatches++;
               $display("%0t: decision word with none expected: speech %0b energy %0d noise %0d",
                        $time, got.speech, got.energy, got.noise);
            end else begin
               want = decision_q.pop_front();
               if (got.speech !== want.speech) begin
                  mismatches++;
                  $display("%0t: speech_active expected %0b actual %0b",
                           $time, want.speech, got.speech);
               end
               if (got.energy !== want.energy) begin
                  mismatches++;
                  $display("%0t: frame_log_energy expected %0d actual %0d",
                           $time, want.energy, got.energy);
               end
               if (got.noise !== want.noise) begin
                  mismatches++;
                  $display("%0t: noise_level expected %0d actual %0d",
                           $time, want.noise, got.noise);
               end
            end
         end
      end
      fails <= mismatches;
      pending <= decision_q.size();
   end

endmodule

@@ tb/energy_voice_activity_detector_tb.sv @@
// testbench top: clock, reset, band and register stimulus, and the verdict
`timescale 1ns / 1ps

module energy_voice_activity_detector_tb;
   import evad_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam int SETTLE_CYCLES = 100;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_WORDS = 40;
   localparam int FLOOD_WORDS = 280;

   logic clock = 1'b0;
   logic reset;
   int   fail_count;
   int   pending;
   int   cycle_count = 0;
   int   req_calm = 0;
   int   rsp_calm = 0;
   bit   loud = 1'b0;

   evad_req_if req_chan ();
   evad_rsp_if rsp_chan ();
   evad_csr_if csr_chan ();

   energy_voice_activity_detector dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   evad_decision_check frame_check (
      .clock   (clock),
      .reset   (reset),
      .req_mon (req_chan),
      .rsp_mon (rsp_chan),
      .csr_mon (csr_chan),
      .fails   (fail_count),
      .pending (pending)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // idle cycles before the next word, with occasional stretches of none
   function automatic int draw_wait(inout int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm_left = $urandom_range(8, 30);
         return 0;
      end
      return $urandom_range(0, 12);
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_setting(input csr_index_type idx);
      logic [CSR_DATA_W-1:0] top, usual;
      case (idx)
         CSR_LOG_MAX_ENERGY: begin
            top = (1 << LME_W) - 1;
            usual = $urandom_range(1000, 6000);
         end
         CSR_INV_ENERGY_SCALE: begin
            top = '1;
            usual = $urandom >> $urandom_range(4, 24);
         end
         CSR_INV_REDUCTION: begin
            top = (1 << MARGIN_W) - 1;
            usual = $urandom_range(100, 8000);
         end
         CSR_UPDATE_MARGIN: begin
            top = (1 << MARGIN_W) - 1;
            usual = $urandom_range(256, 12000);
         end
         CSR_SPEECH_MARGIN: begin
            top = (1 << MARGIN_W) - 1;
            usual = $urandom_range(0, 6000);
         end
         CSR_MIN_SPEECH_FRAMES: begin
            top = (1 << RUN_W) - 1;
            usual = $urandom_range(0, 8);
         end
         default: begin
            top = (1 << RUN_W) - 1;
            usual = $urandom_range(0, 12);
         end
      endcase
      case ($urandom_range(0, 9))
         0: return '0;
         1: return top;
         default: return usual;
      endcase
   endfunction

   task automatic put_band(input logic [BAND_W-1:0] energy, input logic closes);
      int gap;
      gap = draw_wait(req_calm);
      if (csr_chan.valid) csr_chan.valid <= 1'b0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.band_energy <= energy;
      req_chan.last_band <= closes;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data <= value;
      do @(posedge clock); while (!csr_chan.ready);
   endtask

   // all decisions back, then room for a band word still being summed
   task automatic settle();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic random_frames(input int budget);
      int                sent, bands;
      logic [BAND_W-1:0] value;
      sent = 0;
      while (sent < budget) begin
         if ($urandom_range(0, 3) == 0) loud = !loud;
         bands = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
         for (int b = 0; b < bands; b++) begin
            case ($urandom_range(0, 19))
               0: value = $urandom;
               1: value = '0;
               2: value = '1;
               default: value = loud ? ($urandom >> $urandom_range(0, 6))
                                     : ($urandom >> $urandom_range(14, 31));
            endcase
            put_band(value, b == bands - 1);
         end
         sent += bands;
      end
   endtask

   initial begin : receiver
      int stall;
      rsp_chan.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = draw_wait(rsp_calm);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
      end
   end

   initial begin : stimulus
      csr_index_type idx;
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.band_energy <= '0;
      req_chan.last_band <= 1'b0;
      csr_chan.valid <= 1'b0;
      csr_chan.index <= CSR_LOG_MAX_ENERGY;
      csr_chan.data <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // warm-up frames: log of zero, then each gain choice
      put_band('0, 1'b1);
      put_band('1, 1'b0);
      put_band('1, 1'b1);
      settle();
      write_reg(CSR_LOG_MAX_ENERGY, '0);
      put_band('1, 1'b1);
      settle();
      write_reg(CSR_LOG_MAX_ENERGY, (1 << LME_W) - 1);
      put_band(32'h1234_5678, 1'b0);
      put_band(32'h8000_0000, 1'b1);
      settle();
      write_reg(CSR_LOG_MAX_ENERGY, 3300);
      put_band(32'h8000_0000, 1'b1);
      put_band(32'h0000_0001, 1'b1);
      settle();

      write_reg(CSR_INV_ENERGY_SCALE, '1);
      write_reg(CSR_INV_REDUCTION, (1 << MARGIN_W) - 1);
      write_reg(CSR_UPDATE_MARGIN, (1 << MARGIN_W) - 1);
      write_reg(CSR_SPEECH_MARGIN, '0);
      write_reg(CSR_MIN_SPEECH_FRAMES, '0);
      write_reg(CSR_HANGOVER_FRAMES, (1 << RUN_W) - 1);
      put_band('1, 1'b1);
      put_band('0, 1'b1);
      put_band('1, 1'b1);
      put_band('0, 1'b1);
      settle();

      write_reg(CSR_INV_ENERGY_SCALE, '0);
      write_reg(CSR_INV_REDUCTION, '0);
      write_reg(CSR_UPDATE_MARGIN, '0);
      write_reg(CSR_SPEECH_MARGIN, (1 << MARGIN_W) - 1);
      write_reg(CSR_MIN_SPEECH_FRAMES, (1 << RUN_W) - 1);
      write_reg(CSR_HANGOVER_FRAMES, '0);
      put_band(32'h7FFF_FFFF, 1'b1);
      put_band('0, 1'b1);
      settle();

      // speech run long enough to arm the hangover, then quiet frames
      write_reg(CSR_LOG_MAX_ENERGY, CSR_DATA_W'(RST_LOG_MAX_ENERGY));
      write_reg(CSR_INV_ENERGY_SCALE, RST_INV_ENERGY_SCALE);
      write_reg(CSR_INV_REDUCTION, CSR_DATA_W'(RST_INV_REDUCTION));
      write_reg(CSR_UPDATE_MARGIN, CSR_DATA_W'(RST_UPDATE_MARGIN));
      write_reg(CSR_SPEECH_MARGIN, CSR_DATA_W'(RST_SPEECH_MARGIN));
      write_reg(CSR_MIN_SPEECH_FRAMES, CSR_DATA_W'(RST_MIN_SPEECH_FRAMES));
      write_reg(CSR_HANGOVER_FRAMES, CSR_DATA_W'(RST_HANGOVER_FRAMES));
      put_band(32'h0000_0100, 1'b1);
      repeat (5) put_band('1, 1'b1);
      repeat (3) put_band(32'h0000_0100, 1'b1);
      settle();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         idx = idx.first();
         do begin
            if ($urandom_range(0, 1) == 1) write_reg(idx, pick_setting(idx));
            idx = idx.next();
         end while (idx != idx.first());
         // one frame loud and long enough to saturate the sum
         if (p == 2) begin
            for (int b = 0; b < FLOOD_WORDS; b++) begin
               put_band($urandom | 32'hFC00_0000, b == FLOOD_WORDS - 1);
            end
         end
         random_frames(PHASE_WORDS);
         settle();
      end

      if (fail_count == 0 && pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hdl/evad_pkg.sv
hdl/evad_if.sv
hdl/evad_mul.sv
hdl/energy_voice_activity_detector.sv
tb/evad_decision_check.sv
tb/energy_voice_activity_detector_tb.sv
